[src/kvls_pkg.sv]
`default_nettype none
package kvls_pkg;

  localparam int MAX_KEYS_DEF = 256;
  localparam int TIME_W       = 32;
  localparam int COMP_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int HELD_W       = 9;
  localparam int COMP_N       = 3;
  localparam int DIV_CNT_W    = $clog2(FRAC_BITS);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_SCAN
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic    load_in;
    logic    res_zero;
    status_t res_status;
    logic    do_append;
    logic    do_clear;
    rd_sel_t rd_sel;
    logic    copy_rd;
    logic    scan_reset;
    logic    scan_step;
    logic    capture_seg;
    logic    div_step;
    logic    comp_reset;
    logic    mul;
    logic    add;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    full;
    logic    n_zero;
    logic    n_one;
    logic    t_le_rd;
    logic    t_ge_rd;
    logic    t_lt_rd;
    logic    div_last;
    logic    comp_last;
    logic    out_busy;
  } sts_t;

  function automatic logic signed [COMP_W-1:0] vec_comp(vec3_t v, logic [1:0] idx);
    logic signed [COMP_W-1:0] c;
    unique case (idx)
      2'd0:    c = v.x;
      2'd1:    c = v.y;
      default: c = v.z;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[src/keyframe_vec3_lerp_sampler.sv]
// Append, clear and unused items go from dispatch straight to the done state.
// A sample item first checks the first and last keys; otherwise the linear scan
// reads one key a cycle from the key memory, then a restoring divider forms
// the 16-bit fraction and one shared multiplier interpolates the three components.
// One item is worked on at a time; the next can be taken in the cycle after a result is
// handed to the output register. Reset empties the key table and drops any result.
`default_nettype none
module keyframe_vec3_lerp_sampler #(
  parameter int MAX_KEYS = kvls_pkg::MAX_KEYS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_ready,
  input  wire logic [1:0]                         action,
  input  wire logic [kvls_pkg::TIME_W-1:0]        time_value,
  input  wire logic signed [kvls_pkg::COMP_W-1:0] comp_x,
  input  wire logic signed [kvls_pkg::COMP_W-1:0] comp_y,
  input  wire logic signed [kvls_pkg::COMP_W-1:0] comp_z,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output logic signed [kvls_pkg::COMP_W-1:0]      out_x,
  output logic signed [kvls_pkg::COMP_W-1:0]      out_y,
  output logic signed [kvls_pkg::COMP_W-1:0]      out_z,
  output logic [1:0]                              status,
  output logic [kvls_pkg::HELD_W-1:0]             keys_held
);
  import kvls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kvls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kvls_dpath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .time_value   (time_value),
    .comp_x       (comp_x),
    .comp_y       (comp_y),
    .comp_z       (comp_z),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .status       (status),
    .keys_held    (keys_held)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while another item is in progress");

  a_empty_gives_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_EMPTY |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("empty table result carries a non-zero vector");

  a_full_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FULL |-> keys_held == HELD_W'(MAX_KEYS))
    else $error("append dropped while the table was not full");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && !result_ready))
    else $error("result register overwritten while its item was still waiting");

endmodule
`default_nettype wire

[src/kvls_ctrl.sv]
`default_nettype none
module kvls_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire kvls_pkg::sts_t sts,
  output kvls_pkg::cmd_t      cmd
);
  import kvls_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.act == ACT_SAMPLE && !sts.n_zero) state_next = S_CHK_FIRST;
        else state_next = S_DONE;
      end
      S_CHK_FIRST: begin
        if (sts.n_one || sts.t_le_rd) state_next = S_DONE;
        else state_next = S_CHK_LAST;
      end
      S_CHK_LAST: begin
        if (sts.t_ge_rd) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.t_lt_rd) state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        if (sts.comp_last) state_next = S_DONE;
        else state_next = S_MUL;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ZERO;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready  = 1'b1;
        cmd.load_in = item_valid;
      end
      S_DISPATCH: begin
        cmd.res_zero = 1'b1;
        priority if (sts.act == ACT_APPEND && sts.full) begin
          cmd.res_status = ST_FULL;
        end else if (sts.act == ACT_SAMPLE && sts.n_zero) begin
          cmd.res_status = ST_EMPTY;
        end else begin
          cmd.res_status = ST_OK;
        end
        cmd.do_append = (sts.act == ACT_APPEND) && !sts.full;
        cmd.do_clear  = (sts.act == ACT_CLEAR);
        cmd.rd_sel    = RD_ZERO;
      end
      S_CHK_FIRST: begin
        cmd.rd_sel  = RD_LAST;
        cmd.copy_rd = sts.n_one || sts.t_le_rd;
      end
      S_CHK_LAST: begin
        cmd.copy_rd    = sts.t_ge_rd;
        cmd.rd_sel     = RD_ZERO;
        cmd.scan_reset = 1'b1;
      end
      S_SCAN: begin
        cmd.rd_sel      = RD_SCAN;
        cmd.capture_seg = sts.t_lt_rd;
        cmd.scan_step   = !sts.t_lt_rd;
      end
      S_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.comp_reset = 1'b1;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_ADD: begin
        cmd.add = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/kvls_dpath.sv]
`default_nettype none
module kvls_dpath #(
  parameter int MAX_KEYS = kvls_pkg::MAX_KEYS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire kvls_pkg::cmd_t                     cmd,
  output kvls_pkg::sts_t                          sts,
  input  wire logic [1:0]                         action,
  input  wire logic [kvls_pkg::TIME_W-1:0]        time_value,
  input  wire logic signed [kvls_pkg::COMP_W-1:0] comp_x,
  input  wire logic signed [kvls_pkg::COMP_W-1:0] comp_y,
  input  wire logic signed [kvls_pkg::COMP_W-1:0] comp_z,
  input  wire logic                               result_ready,
  output logic                                    result_valid,
  output logic signed [kvls_pkg::COMP_W-1:0]      out_x,
  output logic signed [kvls_pkg::COMP_W-1:0]      out_y,
  output logic signed [kvls_pkg::COMP_W-1:0]      out_z,
  output logic [1:0]                              status,
  output logic [kvls_pkg::HELD_W-1:0]             keys_held
);
  import kvls_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int PW = COMP_W + 1 + FRAC_BITS + 1;

  action_t             act_r;
  logic [TIME_W-1:0]   t_r;
  vec3_t               in_vec;
  logic [CW-1:0]       key_total;
  logic [CW-1:0]       last_idx;

  logic [TIME_W-1:0]   tmem [MAX_KEYS];
  vec3_t               vmem [MAX_KEYS];
  logic [AW-1:0]       rd_addr;
  logic [TIME_W-1:0]   rd_t;
  vec3_t               rd_vec;

  logic [AW-1:0]       scan_addr;
  logic [TIME_W-1:0]   prev_t;
  vec3_t               prev_vec;
  vec3_t               a_vec;
  vec3_t               b_vec;

  logic [TIME_W-1:0]   span;
  logic [TIME_W-1:0]   rem;
  logic [TIME_W:0]     rem_sh;
  logic                div_ge;
  logic [FRAC_BITS-1:0] quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [1:0]               comp_idx;
  logic signed [COMP_W-1:0] a_c;
  logic signed [COMP_W-1:0] b_c;
  logic signed [COMP_W:0]   d_c;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     prod_sh;
  logic signed [COMP_W-1:0] sum_c;

  vec3_t               res_vec;
  status_t             res_status;
  vec3_t               out_vec;
  status_t             out_status;
  logic [CW-1:0]       out_held;

  assign last_idx = key_total - CW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LAST: rd_addr = last_idx[AW-1:0];
      RD_SCAN: rd_addr = scan_addr;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r    <= action_t'(action);
      t_r      <= time_value;
      in_vec.x <= comp_x;
      in_vec.y <= comp_y;
      in_vec.z <= comp_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_total <= '0;
    end else if (cmd.do_clear) begin
      key_total <= '0;
    end else if (cmd.do_append) begin
      key_total <= key_total + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_append) begin
      tmem[key_total[AW-1:0]] <= t_r;
      vmem[key_total[AW-1:0]] <= in_vec;
    end
    rd_t   <= tmem[rd_addr];
    rd_vec <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_reset) begin
      scan_addr <= AW'(1);
    end else if (cmd.scan_step) begin
      scan_addr <= scan_addr + AW'(1);
      prev_t    <= rd_t;
      prev_vec  <= rd_vec;
    end
  end

  assign rem_sh = {rem, 1'b0};
  assign div_ge = rem_sh >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.capture_seg) begin
      a_vec   <= prev_vec;
      b_vec   <= rd_vec;
      span    <= rd_t - prev_t;
      rem     <= t_r - prev_t;
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= div_ge ? TIME_W'(rem_sh - {1'b0, span}) : rem_sh[TIME_W-1:0];
      quo     <= {quo[FRAC_BITS-2:0], div_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign a_c     = vec_comp(a_vec, comp_idx);
  assign b_c     = vec_comp(b_vec, comp_idx);
  assign d_c     = {b_c[COMP_W-1], b_c} - {a_c[COMP_W-1], a_c};
  assign frac_s  = {1'b0, quo};
  assign prod_sh = prod >>> FRAC_BITS;
  assign sum_c   = a_c + prod_sh[COMP_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= d_c * frac_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_reset) begin
      comp_idx <= '0;
    end else if (cmd.add) begin
      comp_idx <= comp_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res_vec    <= '0;
      res_status <= cmd.res_status;
    end else if (cmd.copy_rd) begin
      res_vec <= rd_vec;
    end else if (cmd.add) begin
      unique case (comp_idx)
        2'd0:    res_vec.x <= sum_c;
        2'd1:    res_vec.y <= sum_c;
        default: res_vec.z <= sum_c;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vec    <= res_vec;
      out_status <= res_status;
      out_held   <= key_total;
    end
  end

  assign out_x     = out_vec.x;
  assign out_y     = out_vec.y;
  assign out_z     = out_vec.z;
  assign status    = out_status;
  assign keys_held = HELD_W'(out_held);

  assign sts.act       = act_r;
  assign sts.full      = key_total == CW'(MAX_KEYS);
  assign sts.n_zero    = key_total == '0;
  assign sts.n_one     = key_total == CW'(1);
  assign sts.t_le_rd   = t_r <= rd_t;
  assign sts.t_ge_rd   = t_r >= rd_t;
  assign sts.t_lt_rd   = t_r < rd_t;
  assign sts.div_last  = div_cnt == DIV_CNT_W'(FRAC_BITS - 1);
  assign sts.comp_last = comp_idx == 2'(COMP_N - 1);
  assign sts.out_busy  = result_valid && !result_ready;

endmodule
`default_nettype wire
